// ----- rtl/skseq_pkg.sv -----
// Shared types and constants for the sprite keyframe sequencer.
`default_nettype none

package skseq_pkg;

    // Field and datapath widths
    localparam int TIME_W     = 32;
    localparam int SPRITE_W   = 16;
    localparam int DELTA_W    = 24;
    localparam int KIDX_W     = 4;
    localparam int MODE_W     = 2;
    localparam int KCNT_W     = 5;
    localparam int RT_W       = 33;   // running time, kept below 2 * duration
    localparam int SUM_W      = 34;   // running time plus one step
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Restoring modulo: one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = 6;

    // Loop modes (code 3 behaves like looping)
    localparam logic [MODE_W-1:0] MODE_HOLD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KF_COUNT  = 2'd2;

    // Item kinds
    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_LOAD    = 1'b1;

    // Reset values of the configuration registers
    localparam logic [MODE_W-1:0] RST_LOOP_MODE = MODE_LOOP;
    localparam logic [TIME_W-1:0] RST_DURATION  = 32'd65536;
    localparam logic [KCNT_W-1:0] RST_KF_COUNT  = 5'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MAP,
        ST_LAUNCH,
        ST_SEARCH,
        ST_HOLD
    } state_t;

    // Search wave passed from cell to cell
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [SPRITE_W-1:0] sprite;
    } srch_t;

endpackage

`default_nettype wire

// ----- rtl/skseq_cell.sv -----
// One keyframe slot: stores start and sprite, and takes part in the search wave.
`default_nettype none

module skseq_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          wr_en,
    input  wire [skseq_pkg::TIME_W-1:0]  wr_start,
    input  wire [skseq_pkg::SPRITE_W-1:0] wr_sprite,
    input  wire [skseq_pkg::TIME_W-1:0]  t,
    input  wire [IW-1:0]                 last_idx,
    input  skseq_pkg::srch_t             link_in,
    output skseq_pkg::srch_t             link_out
);
    import skseq_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [TIME_W-1:0]   start_reg;
    logic [SPRITE_W-1:0] sprite_reg;
    logic                valid_reg;
    logic                valid_next;
    logic                found_reg;
    logic                found_next;
    logic [SPRITE_W-1:0] link_sprite_reg;
    logic [SPRITE_W-1:0] link_sprite_next;
    logic                take;

    // Slot storage, written by load items only
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_reg  <= wr_start;
            sprite_reg <= wr_sprite;
        end
    end

    // First active slot at or after t wins; the last active slot is the fallback
    always_comb
    begin
        take = link_in.valid && !link_in.found && (MY_IDX <= last_idx)
               && ((start_reg >= t) || (MY_IDX == last_idx));
        valid_next       = link_in.valid;
        found_next       = link_in.found | take;
        link_sprite_next = take ? sprite_reg : link_in.sprite;
    end

    // Wave valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Wave payload
    always_ff @(posedge clk)
    begin
        found_reg       <= found_next;
        link_sprite_reg <= link_sprite_next;
    end

    assign link_out = '{valid: valid_reg, found: found_reg, sprite: link_sprite_reg};

endmodule

`default_nettype wire

// ----- rtl/skseq_mod.sv -----
// Iterative restoring modulo unit: remainder of a 34-bit value by a 33-bit divisor.
`default_nettype none

module skseq_mod (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [skseq_pkg::SUM_W-1:0]   dividend,
    input  wire [skseq_pkg::RT_W-1:0]    divisor,
    output logic                         done,
    output logic [skseq_pkg::RT_W-1:0]   rem
);
    import skseq_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [SUM_W-1:0]     dvd_reg;
    logic [RT_W-1:0]      dsr_reg;
    logic [RT_W-1:0]      rem_reg;
    logic [SUM_W-1:0]     trial;
    logic [SUM_W-1:0]     diff;
    logic [RT_W-1:0]      rem_step;

    // One shift-and-subtract step; the remainder stays below a nonzero divisor
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SUM_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_step = (trial >= {1'b0, dsr_reg}) ? diff[RT_W-1:0] : trial[RT_W-1:0];
    end

    // Step counter and completion pulse
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/sprite_keyframe_sequencer_top.sv -----
// Sprite keyframe sequencer: time update, loop mapping and keyframe search.
//
// One item at a time. A load item writes its slot on acceptance; an advance item adds
// its step to the running time. Either way one result follows with the mapped time and
// the sprite of the first active slot whose start is at or after it (or the last active
// slot). In ping-pong and looping modes the time passes a 34-step restoring modulo unit;
// in play-to-end mode, or with zero duration, the modulo is skipped. The search wave
// moves one keyframe cell per cycle down the chain of MAX_KEYFRAMES cells. A finished
// result waits in the output register while the next item is taken. Configuration
// writes are always ready and must only happen while the block is idle.
`default_nettype none

module sprite_keyframe_sequencer_top #(
    parameter int MAX_KEYFRAMES = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // Input items
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // delta_time[23:0], key_index[27:24], key_start[59:28], key_sprite[75:60], zeros
    input  wire [skseq_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[0]
    input  wire                                s_tuser,
    // Results
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // sprite_id[15:0], clamped_time[47:16]
    output logic [skseq_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration writes
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [skseq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [skseq_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import skseq_pkg::*;

    localparam int IW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;

    // Configuration registers
    logic [MODE_W-1:0] loop_mode_reg;
    logic [TIME_W-1:0] duration_reg;
    logic [KCNT_W-1:0] kf_count_reg;

    // Control
    state_t            state_reg;
    state_t            state_next;
    logic              s_accept;
    logic              cfg_accept;
    logic              need_div;
    logic              div_start;
    logic              map_en;
    logic              inject;
    logic              res_capture;
    logic              out_load;
    logic              out_free;

    // Item and datapath
    logic                kind_reg;
    logic [DELTA_W-1:0]  delta_reg;
    logic [RT_W-1:0]     rt_reg;
    logic [RT_W-1:0]     rt_next;
    logic [TIME_W-1:0]   t_reg;
    logic [TIME_W-1:0]   t_next;
    logic [SPRITE_W-1:0] res_sprite_reg;
    logic                out_valid_reg;
    logic [SPRITE_W-1:0] out_sprite_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    clamp_src;
    logic [SUM_W-1:0]    clamped;
    logic [RT_W-1:0]     two_d;
    logic [RT_W-1:0]     mod_rem;
    logic                mod_done;
    logic                rem_ge;
    logic [RT_W-1:0]     rem_minus_d;
    logic [RT_W-1:0]     mirror;
    logic [IW-1:0]       last_idx;

    // Input field views
    logic [KIDX_W-1:0]   key_index;
    logic [TIME_W-1:0]   key_start;
    logic [SPRITE_W-1:0] key_sprite;

    // Search chain
    srch_t               link [MAX_KEYFRAMES+1];

    assign key_index  = s_tdata[27:24];
    assign key_start  = s_tdata[59:28];
    assign key_sprite = s_tdata[75:60];

    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || m_tready;
    assign need_div   = (loop_mode_reg != MODE_HOLD) && (duration_reg != '0);

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_mode_reg <= RST_LOOP_MODE;
            duration_reg  <= RST_DURATION;
            kf_count_reg  <= RST_KF_COUNT;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_LOOP_MODE: loop_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_DURATION:  duration_reg  <= cfg_data[TIME_W-1:0];
                CFG_KF_COUNT:  kf_count_reg  <= cfg_data[KCNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Last slot in the search: count clamped to 1..MAX_KEYFRAMES
    always_comb
    begin
        if (kf_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(kf_count_reg) > MAX_KEYFRAMES)
        begin
            last_idx = IW'(MAX_KEYFRAMES - 1);
        end
        else
        begin
            last_idx = IW'(kf_count_reg - 5'd1);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_PREP;
            ST_PREP:   state_next = need_div ? ST_DIV : ST_MAP;
            ST_DIV:    if (mod_done) state_next = ST_MAP;
            ST_MAP:    state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_SEARCH;
            ST_SEARCH: if (link[MAX_KEYFRAMES].valid) state_next = ST_HOLD;
            ST_HOLD:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready    = 1'b0;
        div_start   = 1'b0;
        map_en      = 1'b0;
        inject      = 1'b0;
        res_capture = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready    = 1'b1;
            ST_PREP:   div_start   = need_div;
            ST_DIV:    ;
            ST_MAP:    map_en      = 1'b1;
            ST_LAUNCH: inject      = 1'b1;
            ST_SEARCH: res_capture = link[MAX_KEYFRAMES].valid;
            ST_HOLD:   out_load    = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Item registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg  <= s_tuser;
            delta_reg <= s_tdata[DELTA_W-1:0];
        end
    end

    // Running time plus step (advance) or running time alone (load)
    always_comb
    begin
        sum       = {1'b0, rt_reg} + SUM_W'(delta_reg);
        clamp_src = (kind_reg == KIND_ADVANCE) ? sum : {1'b0, rt_reg};
    end

    skseq_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clamp_src),
        .divisor  (two_d),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Map to [0, duration]: clamp, wrap, or mirror on odd periods
    always_comb
    begin
        two_d       = {duration_reg, 1'b0};
        clamped     = (clamp_src > SUM_W'(duration_reg)) ? SUM_W'(duration_reg) : clamp_src;
        rem_ge      = mod_rem >= RT_W'(duration_reg);
        rem_minus_d = mod_rem - RT_W'(duration_reg);
        mirror      = two_d - mod_rem;
        rt_next     = rt_reg;
        t_next      = '0;
        if (duration_reg == '0)
        begin
            if (kind_reg == KIND_ADVANCE)
            begin
                rt_next = '0;
            end
        end
        else if (loop_mode_reg == MODE_HOLD)
        begin
            t_next = clamped[TIME_W-1:0];
            if (kind_reg == KIND_ADVANCE)
            begin
                rt_next = clamped[RT_W-1:0];
            end
        end
        else
        begin
            if (!rem_ge)
            begin
                t_next = mod_rem[TIME_W-1:0];
            end
            else if (loop_mode_reg == MODE_PINGPONG)
            begin
                t_next = mirror[TIME_W-1:0];
            end
            else
            begin
                t_next = rem_minus_d[TIME_W-1:0];
            end
            if (kind_reg == KIND_ADVANCE)
            begin
                rt_next = mod_rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_reg <= '0;
        end
        else if (map_en)
        begin
            rt_reg <= rt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_en)
        begin
            t_reg <= t_next;
        end
    end

    // Keyframe cell chain
    assign link[0] = '{valid: inject, found: 1'b0, sprite: '0};

    for (genvar i = 0; i < MAX_KEYFRAMES; i++)
    begin : g_cell
        logic wr_en;

        assign wr_en = s_accept && (s_tuser == KIND_LOAD) && (32'(key_index) == i);

        skseq_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en),
            .wr_start  (key_start),
            .wr_sprite (key_sprite),
            .t         (t_reg),
            .last_idx  (last_idx),
            .link_in   (link[i]),
            .link_out  (link[i+1])
        );
    end

    // Search result
    always_ff @(posedge clk)
    begin
        if (res_capture)
        begin
            res_sprite_reg <= link[MAX_KEYFRAMES].sprite;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sprite_reg <= res_sprite_reg;
            out_time_reg   <= t_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_time_reg, out_sprite_reg};

endmodule

`default_nettype wire

// ----- rtl/skseq_checker.sv -----
// Port-level checks for the sprite keyframe sequencer, bound to the top level.
`default_nettype none

module skseq_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [skseq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import skseq_pkg::*;

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Items accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        case ({in_acc, out_acc})
            2'b10:   pend_next = pend_reg + 2'd1;
            2'b01:   pend_next = pend_reg - 2'd1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result without an item in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without a pending item");

    // Ready only with at most one undelivered result
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> pend_reg <= 2'd1)
        else $error("ready while a result is already queued behind another");

    // One item at a time: busy right after acceptance
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after an accepted item");

endmodule

bind sprite_keyframe_sequencer_top skseq_checker u_skseq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
